// File: design/dbrt_pkg.sv
// Package for the DMA buffer ring tracker: item types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none
package dbrt_pkg;

   // ring size default
   localparam int NUM_BUFFERS_DEF = 8;

   // field widths
   localparam int OP_W      = 3;
   localparam int WORD_W    = 32;
   localparam int LEN_W     = 8;
   localparam int KIND_W    = 2;
   localparam int ERR_W     = 3;
   localparam int TAG_W     = 4;
   localparam int BYTES_W   = 22;
   localparam int CSR_IDX_W = 1;

   // operations
   localparam logic [OP_W-1:0] OP_STATUS  = 3'd0;
   localparam logic [OP_W-1:0] OP_GET     = 3'd1;
   localparam logic [OP_W-1:0] OP_CONFIRM = 3'd2;
   localparam logic [OP_W-1:0] OP_START   = 3'd3;
   localparam logic [OP_W-1:0] OP_STOP    = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CMD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GET = 2'd2;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK          = 3'd0;
   localparam logic [ERR_W-1:0] ERR_NOT_READY   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_BAD_LENGTH  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_NOT_OKAY    = 3'd3;
   localparam logic [ERR_W-1:0] ERR_TAG_MISMATCH = 3'd4;
   localparam logic [ERR_W-1:0] ERR_STARTED     = 3'd5;
   localparam logic [ERR_W-1:0] ERR_NOT_STARTED = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE    = 1'b1;

   localparam logic [WORD_W-1:0] BASE_ADDR_RESET = 32'h0000_0000;
   localparam logic [WORD_W-1:0] STRIDE_RESET    = 32'h0040_0000;

   // status word layout
   localparam int OKAY_BIT   = 7;
   localparam int BYTES_LSB  = 8;
   localparam int BYTES_MSB  = 29;
   localparam logic [LEN_W-1:0] STATUS_LEN = 8'd4;

   // transfer command control: max length 0x3fffff, incrementing, end of frame
   localparam logic [WORD_W-1:0] CMD_CONTROL = 32'h40BF_FFFF;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [WORD_W-1:0] status_word;
      logic [LEN_W-1:0]  status_length;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ERR_W-1:0]   error_code;
      logic [WORD_W-1:0]  cmd_control;
      logic [WORD_W-1:0]  cmd_address;
      logic [TAG_W-1:0]   buffer_index;
      logic [BYTES_W-1:0] byte_count;
      logic               buffer_ready;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

// File: design/dma_buffer_ring_tracker.sv
// DMA receive buffer ring tracker: status, get, confirm, start and stop handling.
`timescale 1ns / 1ps
`default_nettype none
// Tracks a ring of NUM_BUFFERS receive buffers. Each accepted item (status word, get,
// confirm, start, stop) is decoded in the cycle it is taken and its result lands in a
// two-entry output queue, so a new item is accepted every cycle while the queue has room,
// even when a finished result is still waiting on rsp_stall. Status, get, confirm and
// stop give one result each; unknown ops give none. A start (when not running) gives
// NUM_BUFFERS transfer commands, one per cycle while the queue has room; req_stall stays
// high after it while the command sequencer walks the ring (plus any output backpressure).
// Buffer addresses are base + index * stride mod 2^32: the sequencer steps an address
// accumulator, confirm uses a narrow index-by-stride product. Configuration is written
// over the csr_ port, which is always ready.
module dma_buffer_ring_tracker
   import dbrt_pkg::*;
#(
   parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   // operation items
   input  wire                   req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // results
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output rsp_type               rsp_data,
   // configuration writes
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [WORD_W-1:0]      csr_data
);

   localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

   // wrap-around ring step
   function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
      next_pos = (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   // configuration
   logic [WORD_W-1:0] base_addr_ff, stride_ff;

   // ring state
   logic [IDX_W-1:0]   exp_tag_ff, exp_tag_in;
   logic [IDX_W-1:0]   read_idx_ff, read_idx_in;
   logic               running_ff, running_in;
   logic               ready_ff [NUM_BUFFERS];
   logic               ready_in [NUM_BUFFERS];
   logic [BYTES_W-1:0] len_ff   [NUM_BUFFERS];
   logic [BYTES_W-1:0] len_in   [NUM_BUFFERS];

   // start command sequencer
   logic              burst_ff, burst_in;
   logic [IDX_W-1:0]  burst_idx_ff, burst_idx_in;
   logic [WORD_W-1:0] burst_addr_ff, burst_addr_in;

   // two-entry output queue
   rsp_type     q_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        q_full, push, pop;
   rsp_type     push_data;

   logic               in_accept;
   logic [TAG_W-1:0]   tag;
   logic [IDX_W-1:0]   tag_idx;
   logic               tag_in_ring;
   logic [BYTES_W-1:0] bytes;
   logic [WORD_W-1:0]  confirm_addr;

   assign csr_ready = 1'b1;

   assign q_full    = (count_ff == 2'd2);
   assign req_stall = q_full || burst_ff;
   assign in_accept = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   assign tag         = req_data.status_word[TAG_W-1:0];
   assign tag_idx     = tag[IDX_W-1:0];
   assign tag_in_ring = ({1'b0, tag} < (TAG_W+1)'(NUM_BUFFERS));
   assign bytes       = req_data.status_word[BYTES_MSB:BYTES_LSB];
   // narrow product: the index is IDX_W bits wide, zero-extended to the word width
   assign confirm_addr = base_addr_ff + (WORD_W'(read_idx_ff) * stride_ff);

   always_comb begin
      exp_tag_in    = exp_tag_ff;
      read_idx_in   = read_idx_ff;
      running_in    = running_ff;
      ready_in      = ready_ff;
      len_in        = len_ff;
      burst_in      = burst_ff;
      burst_idx_in  = burst_idx_ff;
      burst_addr_in = burst_addr_ff;
      push          = 1'b0;
      push_data     = '0;
      push_data.last = 1'b1;

      if (burst_ff) begin
         // start sequence: one transfer command per free queue slot
         if (!q_full) begin
            push                   = 1'b1;
            push_data.kind         = KIND_CMD;
            push_data.cmd_control  = CMD_CONTROL;
            push_data.cmd_address  = burst_addr_ff;
            push_data.buffer_index = TAG_W'(burst_idx_ff);
            push_data.last         = (burst_idx_ff == LAST_IDX);
            burst_idx_in           = burst_idx_ff + 1'b1;
            burst_addr_in          = burst_addr_ff + stride_ff;
            if (burst_idx_ff == LAST_IDX) begin
               burst_in = 1'b0;
            end
         end
      end else if (in_accept) begin
         case (req_data.op)
            OP_STATUS: begin
               push                   = 1'b1;
               push_data.kind         = KIND_ACK;
               push_data.buffer_index = tag;
               push_data.byte_count   = bytes;
               if (req_data.status_length != STATUS_LEN) begin
                  push_data.error_code = ERR_BAD_LENGTH;
               end else if (!req_data.status_word[OKAY_BIT]) begin
                  push_data.error_code = ERR_NOT_OKAY;
               end else begin
                  // mismatch is flagged but still applied
                  if (tag != TAG_W'(exp_tag_ff)) begin
                     push_data.error_code = ERR_TAG_MISMATCH;
                  end
                  if (tag_in_ring) begin
                     ready_in[tag_idx]      = 1'b1;
                     len_in[tag_idx]        = bytes;
                     push_data.buffer_ready = 1'b1;
                  end
                  exp_tag_in = next_pos(exp_tag_ff);
               end
            end
            OP_GET: begin
               push                   = 1'b1;
               push_data.kind         = KIND_GET;
               push_data.error_code   = ready_ff[read_idx_ff] ? ERR_OK : ERR_NOT_READY;
               push_data.buffer_index = TAG_W'(read_idx_ff);
               push_data.byte_count   = len_ff[read_idx_ff];
               push_data.buffer_ready = ready_ff[read_idx_ff];
            end
            OP_CONFIRM: begin
               push = 1'b1;
               if (!ready_ff[read_idx_ff]) begin
                  push_data.kind       = KIND_ACK;
                  push_data.error_code = ERR_NOT_READY;
               end else begin
                  ready_in[read_idx_ff]  = 1'b0;
                  len_in[read_idx_ff]    = '0;
                  push_data.kind         = KIND_CMD;
                  push_data.cmd_control  = CMD_CONTROL;
                  push_data.cmd_address  = confirm_addr;
                  push_data.buffer_index = TAG_W'(read_idx_ff);
                  read_idx_in            = next_pos(read_idx_ff);
               end
            end
            OP_START: begin
               push = 1'b1;
               if (running_ff) begin
                  push_data.kind       = KIND_ACK;
                  push_data.error_code = ERR_STARTED;
               end else begin
                  exp_tag_in  = '0;
                  read_idx_in = '0;
                  running_in  = 1'b1;
                  for (int i = 0; i < NUM_BUFFERS; i++) begin
                     ready_in[i] = 1'b0;
                     len_in[i]   = '0;
                  end
                  // buffer zero goes out now, the sequencer does the rest
                  push_data.kind        = KIND_CMD;
                  push_data.cmd_control = CMD_CONTROL;
                  push_data.cmd_address = base_addr_ff;
                  push_data.last        = (NUM_BUFFERS == 1);
                  burst_in              = (NUM_BUFFERS > 1);
                  burst_idx_in          = IDX_W'(1);
                  burst_addr_in         = base_addr_ff + stride_ff;
               end
            end
            OP_STOP: begin
               push                 = 1'b1;
               push_data.kind       = KIND_ACK;
               push_data.error_code = running_ff ? ERR_OK : ERR_NOT_STARTED;
               running_in           = 1'b0;
            end
            default: begin
               // unknown op: taken, no result
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_addr_ff <= BASE_ADDR_RESET;
         stride_ff    <= STRIDE_RESET;
         exp_tag_ff   <= '0;
         read_idx_ff  <= '0;
         running_ff   <= 1'b0;
         burst_ff     <= 1'b0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= 2'd0;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            ready_ff[i] <= 1'b0;
            len_ff[i]   <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_ADDR: base_addr_ff <= csr_data;
               CSR_STRIDE:    stride_ff    <= csr_data;
               default: begin
               end
            endcase
         end
         exp_tag_ff  <= exp_tag_in;
         read_idx_ff <= read_idx_in;
         running_ff  <= running_in;
         burst_ff    <= burst_in;
         ready_ff    <= ready_in;
         len_ff      <= len_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      burst_idx_ff  <= burst_idx_in;
      burst_addr_ff <= burst_addr_in;
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("output queue overflow");

   // no item taken while the start sequence runs
   assert property (@(posedge clock) disable iff (reset) burst_ff |-> req_stall)
      else $error("item accepted during start sequence");

   // transfer commands always carry the fixed control word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_CMD) |-> rsp_data.cmd_control == CMD_CONTROL)
      else $error("transfer command with bad control word");

   // a successful start leaves the block running
   assert property (@(posedge clock) disable iff (reset)
      (in_accept && req_data.op == OP_START && !running_ff) |=> running_ff)
      else $error("start did not set running");

endmodule
`default_nettype wire

// File: test/dma_buffer_ring_tracker_test.sv
// Self-checking testbench for the DMA buffer ring tracker.
`timescale 1ns / 1ps
module dma_buffer_ring_tracker_test;
   import dbrt_pkg::*;

   localparam int NB           = NUM_BUFFERS_DEF;
   localparam int PHASE_ITEMS  = 58;      // counted items per pacing phase
   localparam int CFG_HOLDOFF  = 12;      // covers a full start sequence and then some
   localparam int END_SETTLE   = 20;
   localparam int LIMIT_CYCLES = 200000;

   // one stimulus row: the item, and optionally its single hand-typed result
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BASE_ADDR;
   logic [WORD_W-1:0]    csr_data = '0;

   dma_buffer_ring_tracker #(.NUM_BUFFERS(NB)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Ring state as the testbench sees it (mirrors the block)
   // ---------------------------------------------------------------
   logic [WORD_W-1:0]  cfg_base = BASE_ADDR_RESET;
   logic [WORD_W-1:0]  cfg_stride = STRIDE_RESET;
   int                 ring_tag = 0;        // tag the next status word should carry
   int                 ring_rd = 0;         // read position used by get and confirm
   bit                 ring_full [NB];
   logic [BYTES_W-1:0] ring_bytes [NB];
   bit                 ring_running = 1'b0;

   rsp_type step_results[$];     // results of the item being applied
   rsp_type pending_results[$];  // results still owed by the block, oldest first
   row_type sent_rows[$];        // rows driven and not yet accepted

   // pacing knobs, in percent
   int idle_pct = 0;
   int stall_pct = 0;

   // bookkeeping
   int fail_count = 0;
   int cycles = 0;
   int n_status = 0, n_get = 0, n_confirm = 0, n_start = 0, n_stop = 0, n_ignored = 0;
   int n_checked = 0, n_cmds = 0, n_cfg = 0;

   function automatic rsp_type make_result(logic [KIND_W-1:0] k, logic [ERR_W-1:0] e,
                                           logic [WORD_W-1:0] ctl, logic [WORD_W-1:0] addr,
                                           logic [TAG_W-1:0] idx, logic [BYTES_W-1:0] nb,
                                           logic rdy, logic lst);
      rsp_type r;
      r.kind = k;
      r.error_code = e;
      r.cmd_control = ctl;
      r.cmd_address = addr;
      r.buffer_index = idx;
      r.byte_count = nb;
      r.buffer_ready = rdy;
      r.last = lst;
      return r;
   endfunction

   // base + index * stride, wrapping at 32 bits
   function automatic logic [WORD_W-1:0] buf_addr(int i);
      logic [WORD_W-1:0] idx;
      idx = i;
      return cfg_base + idx * cfg_stride;
   endfunction

   // Apply one accepted item to the ring state and fill step_results.
   task automatic ring_next_results(input req_type it);
      logic [TAG_W-1:0]   tag;
      logic [BYTES_W-1:0] nb;
      logic [ERR_W-1:0]   err;
      logic               kept;
      step_results.delete();
      case (it.op)
         OP_STATUS: begin
            tag  = it.status_word[TAG_W-1:0];
            nb   = it.status_word[BYTES_MSB:BYTES_LSB];
            err  = ERR_OK;
            kept = 1'b0;
            if (it.status_length != STATUS_LEN) begin
               err = ERR_BAD_LENGTH;
            end else if (!it.status_word[OKAY_BIT]) begin
               err = ERR_NOT_OKAY;
            end else begin
               if (int'(tag) != ring_tag) err = ERR_TAG_MISMATCH;
               // a tag past the ring is flagged and stores nothing
               if (int'(tag) < NB) begin
                  ring_bytes[tag] = nb;
                  ring_full[tag] = 1'b1;
                  kept = 1'b1;
               end
               ring_tag = (ring_tag + 1 >= NB) ? 0 : ring_tag + 1;
            end
            step_results.push_back(make_result(KIND_ACK, err, '0, '0, tag, nb, kept, 1'b1));
         end
         OP_GET: begin
            step_results.push_back(make_result(KIND_GET,
               ring_full[ring_rd] ? ERR_OK : ERR_NOT_READY, '0, '0, TAG_W'(ring_rd),
               ring_bytes[ring_rd], ring_full[ring_rd], 1'b1));
         end
         OP_CONFIRM: begin
            if (!ring_full[ring_rd]) begin
               step_results.push_back(make_result(KIND_ACK, ERR_NOT_READY, '0, '0, '0, '0,
                                                  1'b0, 1'b1));
            end else begin
               ring_full[ring_rd] = 1'b0;
               ring_bytes[ring_rd] = '0;
               step_results.push_back(make_result(KIND_CMD, ERR_OK, CMD_CONTROL,
                  buf_addr(ring_rd), TAG_W'(ring_rd), '0, 1'b0, 1'b1));
               ring_rd = (ring_rd + 1 >= NB) ? 0 : ring_rd + 1;
            end
         end
         OP_START: begin
            if (ring_running) begin
               step_results.push_back(make_result(KIND_ACK, ERR_STARTED, '0, '0, '0, '0,
                                                  1'b0, 1'b1));
            end else begin
               ring_tag = 0;
               ring_rd = 0;
               for (int i = 0; i < NB; i++) begin
                  ring_full[i] = 1'b0;
                  ring_bytes[i] = '0;
                  step_results.push_back(make_result(KIND_CMD, ERR_OK, CMD_CONTROL,
                     buf_addr(i), TAG_W'(i), '0, 1'b0, i == NB - 1));
               end
               ring_running = 1'b1;
            end
         end
         OP_STOP: begin
            step_results.push_back(make_result(KIND_ACK,
               ring_running ? ERR_OK : ERR_NOT_STARTED, '0, '0, '0, '0, 1'b0, 1'b1));
            ring_running = 1'b0;
         end
         default: ;  // unknown ops produce nothing
      endcase
   endtask

   task automatic check_result(input rsp_type got, input rsp_type want);
      bit bad;
      bad = (got.kind !== want.kind) || (got.error_code !== want.error_code) ||
            (got.cmd_control !== want.cmd_control) ||
            (got.cmd_address !== want.cmd_address) ||
            (got.buffer_index !== want.buffer_index) ||
            (got.byte_count !== want.byte_count) ||
            (got.buffer_ready !== want.buffer_ready) || (got.last !== want.last);
      if (bad) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("mismatch at cycle %0d", cycles);
            $display("  exp kind=%0d err=%0d ctl=%h addr=%h idx=%0d bytes=%h rdy=%b last=%b",
                     want.kind, want.error_code, want.cmd_control, want.cmd_address,
                     want.buffer_index, want.byte_count, want.buffer_ready, want.last);
            $display("  got kind=%0d err=%0d ctl=%h addr=%h idx=%0d bytes=%h rdy=%b last=%b",
                     got.kind, got.error_code, got.cmd_control, got.cmd_address,
                     got.buffer_index, got.byte_count, got.buffer_ready, got.last);
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Scoreboard: everything is sampled at the rising edge, so we see
   // the values the block saw. Predict first, then check, so even a
   // same-cycle result would find its expectation in place.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      row_type row;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BASE_ADDR) cfg_base = csr_data;
            else cfg_stride = csr_data;
            n_cfg++;
         end
         if (req_valid && !req_stall) begin
            if (sent_rows.size() != 0) begin
               row = sent_rows.pop_front();
            end else begin
               row.item = '0;
               row.typed = 1'b0;
               row.want = '0;
            end
            ring_next_results(req_data);
            // a hand-typed row replaces a single predicted result with the typed value
            if (row.typed && step_results.size() == 1) begin
               pending_results.push_back(row.want);
            end else begin
               foreach (step_results[i]) pending_results.push_back(step_results[i]);
            end
            case (req_data.op)
               OP_STATUS:  n_status++;
               OP_GET:     n_get++;
               OP_CONFIRM: n_confirm++;
               OP_START:   n_start++;
               OP_STOP:    n_stop++;
               default:    n_ignored++;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result at cycle %0d: kind=%0d err=%0d idx=%0d",
                           cycles, rsp_data.kind, rsp_data.error_code, rsp_data.buffer_index);
            end else begin
               check_result(rsp_data, pending_results.pop_front());
            end
            n_checked++;
            if (rsp_data.kind == KIND_CMD) n_cmds++;
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_results.size());
         $display("dma_buffer_ring_tracker_test NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------
   // Drive one item and hold it until accepted. Valid stays high on
   // return so back-to-back items need no extra edge.
   task automatic send_item(input row_type r);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      sent_rows.push_back(r);
      req_valid <= 1'b1;
      req_data  <= r.item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Sender goes quiet until every owed result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Both registers, back to back; only called with the block idle.
   task automatic set_ring_config(input logic [WORD_W-1:0] base,
                                  input logic [WORD_W-1:0] stride);
      csr_valid <= 1'b1;
      csr_index <= CSR_BASE_ADDR;
      csr_data  <= base;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_STRIDE;
      csr_data  <= stride;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_req(logic [OP_W-1:0] op, logic [WORD_W-1:0] word,
                                        logic [LEN_W-1:0] len);
      req_type it;
      it.op = op;
      it.status_word = word;
      it.status_length = len;
      return it;
   endfunction

   // Random item. Status words mostly well formed and carrying the tag the
   // ring expects, so buffers fill and confirms find ready data.
   function automatic req_type random_item();
      req_type it;
      int      sel;
      sel = $urandom_range(99);
      it.status_word = $urandom();
      it.status_length = LEN_W'($urandom_range(255));
      if (sel < 45) begin
         it.op = OP_STATUS;
         it.status_length = STATUS_LEN;
         if ($urandom_range(99) < 80) it.status_word[TAG_W-1:0] = TAG_W'(ring_tag);
         it.status_word[OKAY_BIT] = $urandom_range(99) < 90;
         case ($urandom_range(9))
            0: it.status_word[BYTES_MSB:BYTES_LSB] = '0;
            1: it.status_word[BYTES_MSB:BYTES_LSB] = '1;
            default: ;
         endcase
         // broken packet lengths now and then
         if ($urandom_range(99) < 10) it.status_length = LEN_W'($urandom_range(255));
      end else if (sel < 60) begin
         it.op = OP_GET;
      end else if (sel < 85) begin
         it.op = OP_CONFIRM;
      end else if (sel < 91) begin
         it.op = OP_START;
      end else if (sel < 97) begin
         it.op = OP_STOP;
      end else begin
         it.op = OP_W'($urandom_range(5, 7));  // unknown op, ignored by the block
      end
      return it;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   row_type directed[$];

   function automatic row_type typed_row(req_type it, rsp_type want);
      row_type r;
      r.item = it;
      r.typed = 1'b1;
      r.want = want;
      return r;
   endfunction

   function automatic row_type open_row(req_type it);
      row_type r;
      r.item = it;
      r.typed = 1'b0;
      r.want = '0;
      return r;
   endfunction

   initial begin : stimulus
      req_type it;
      int      n;
      int      waited;
      int      ph;
      logic [WORD_W-1:0] phase_base [4];
      logic [WORD_W-1:0] phase_stride [4];
      int      phase_idle [4];
      int      phase_stall [4];

      for (int i = 0; i < NB; i++) begin
         ring_full[i] = 1'b0;
         ring_bytes[i] = '0;
      end

      // Directed table, run under reset configuration.
      // after reset: nothing ready, nothing started
      directed.push_back(typed_row(make_req(OP_GET, '0, STATUS_LEN),
         make_result(KIND_GET, ERR_NOT_READY, '0, '0, '0, '0, 1'b0, 1'b1)));
      directed.push_back(typed_row(make_req(OP_CONFIRM, '0, STATUS_LEN),
         make_result(KIND_ACK, ERR_NOT_READY, '0, '0, '0, '0, 1'b0, 1'b1)));
      directed.push_back(typed_row(make_req(OP_STOP, '0, STATUS_LEN),
         make_result(KIND_ACK, ERR_NOT_STARTED, '0, '0, '0, '0, 1'b0, 1'b1)));
      // short packet, all ones word: dropped, fields still echoed
      directed.push_back(typed_row(make_req(OP_STATUS, 32'hFFFF_FFFF, 8'd3),
         make_result(KIND_ACK, ERR_BAD_LENGTH, '0, '0, 4'hF, '1, 1'b0, 1'b1)));
      // OKAY clear: dropped
      directed.push_back(typed_row(make_req(OP_STATUS, 32'h3FFF_FF70, STATUS_LEN),
         make_result(KIND_ACK, ERR_NOT_OKAY, '0, '0, '0, '1, 1'b0, 1'b1)));
      directed.push_back(open_row(make_req(OP_START, '0, STATUS_LEN)));
      directed.push_back(typed_row(make_req(OP_START, '0, STATUS_LEN),
         make_result(KIND_ACK, ERR_STARTED, '0, '0, '0, '0, 1'b0, 1'b1)));
      // good word, tag 0, largest byte count
      directed.push_back(typed_row(make_req(OP_STATUS, 32'h3FFF_FF80, STATUS_LEN),
         make_result(KIND_ACK, ERR_OK, '0, '0, '0, '1, 1'b1, 1'b1)));
      // tag skips ahead: flagged but stored
      directed.push_back(typed_row(make_req(OP_STATUS, 32'h0000_0082, STATUS_LEN),
         make_result(KIND_ACK, ERR_TAG_MISMATCH, '0, '0, 4'd2, '0, 1'b1, 1'b1)));
      // tag past the ring, top bits set: flagged, nothing stored
      directed.push_back(typed_row(make_req(OP_STATUS, 32'hC000_008F, STATUS_LEN),
         make_result(KIND_ACK, ERR_TAG_MISMATCH, '0, '0, 4'hF, '0, 1'b0, 1'b1)));
      directed.push_back(open_row(make_req(OP_GET, '0, STATUS_LEN)));
      directed.push_back(open_row(make_req(OP_CONFIRM, '0, STATUS_LEN)));
      directed.push_back(open_row(make_req(OP_GET, '0, STATUS_LEN)));
      directed.push_back(open_row(make_req(OP_STATUS, 32'h1234_5681, STATUS_LEN)));
      directed.push_back(open_row(make_req(OP_CONFIRM, '0, STATUS_LEN)));
      directed.push_back(open_row(make_req(OP_CONFIRM, '0, STATUS_LEN)));
      directed.push_back(open_row(make_req(3'd5, 32'hFFFF_FFFF, 8'hFF)));
      directed.push_back(open_row(make_req(3'd7, 32'hFFFF_FFFF, 8'hFF)));
      directed.push_back(typed_row(make_req(OP_STATUS, '0, 8'hFF),
         make_result(KIND_ACK, ERR_BAD_LENGTH, '0, '0, '0, '0, 1'b0, 1'b1)));
      directed.push_back(typed_row(make_req(OP_STATUS, 32'h0000_0080, 8'd0),
         make_result(KIND_ACK, ERR_BAD_LENGTH, '0, '0, '0, '0, 1'b0, 1'b1)));
      directed.push_back(typed_row(make_req(OP_STOP, '0, STATUS_LEN),
         make_result(KIND_ACK, ERR_OK, '0, '0, '0, '0, 1'b0, 1'b1)));
      directed.push_back(typed_row(make_req(OP_STOP, '0, STATUS_LEN),
         make_result(KIND_ACK, ERR_NOT_STARTED, '0, '0, '0, '0, 1'b0, 1'b1)));
      directed.push_back(open_row(make_req(3'd6, '0, '0)));
      // status words are taken while stopped too
      directed.push_back(open_row(make_req(OP_STATUS, 32'h0ABC_DE84, STATUS_LEN)));
      directed.push_back(open_row(make_req(OP_START, '0, STATUS_LEN)));

      // pacing phases: none, sender idle, receiver stall, both
      phase_idle   = '{0, 56, 0, 25};
      phase_stall  = '{0, 0, 56, 25};
      phase_base   = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom(), 32'h8000_0000};
      phase_stride = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom(), 32'h0000_0001};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i]);

      for (ph = 0; ph < 4; ph++) begin
         // configuration only with the block quiet
         wait_drained();
         repeat (CFG_HOLDOFF) @(posedge clock);
         set_ring_config(phase_base[ph], phase_stride[ph]);
         idle_pct  = phase_idle[ph];
         stall_pct = phase_stall[ph];
         n = 0;
         while (n < PHASE_ITEMS) begin
            it = random_item();
            send_item(open_row(it));
            if (it.op <= OP_STOP) n++;
            // let the whole pipe empty once under backpressure
            if (ph == 2 && n == PHASE_ITEMS / 2) wait_drained();
         end
      end

      // drain, then watch a little longer for stray results
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      stall_pct = 0;
      repeat (END_SETTLE) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0d expected results never arrived", pending_results.size());
         fail_count += pending_results.size();
      end

      $display("ran %0d status, %0d get, %0d confirm, %0d start, %0d stop, %0d ignored items",
               n_status, n_get, n_confirm, n_start, n_stop, n_ignored);
      $display("checked %0d results (%0d transfer commands) over %0d register writes, %0d fails",
               n_checked, n_cmds, n_cfg, fail_count);
      if (fail_count == 0) begin
         $display("dma_buffer_ring_tracker_test OK");
      end else begin
         $display("dma_buffer_ring_tracker_test NOT OK");
      end
      $finish;
   end

endmodule
